// File: hw/rtl/jkv_pkg.sv
package jkv_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_IDX_W   = $clog2(KEY_BYTES + 1);
    localparam int KEY_SEL_W   = $clog2(KEY_BYTES);
    localparam int BUF_BYTES   = 256;
    localparam int LEN_W       = $clog2(BUF_BYTES + 1);
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DATA_W  = 16;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_BRACE = 8'h7D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_F     = 8'h66;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 3'd0,
        CFG_KEY_HIGH = 3'd1,
        CFG_KEY_LEN  = 3'd2,
        CFG_KIND     = 3'd3,
        CFG_CAPACITY = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_NOT_FOUND    = 3'd1,
        STATUS_WRONG_TYPE   = 3'd2,
        STATUS_UNTERMINATED = 3'd3,
        STATUS_TOO_LONG     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_CAND   = 3'd1,
        PH_COLON  = 3'd2,
        PH_BLANK  = 3'd3,
        PH_STRING = 3'd4,
        PH_WORD   = 3'd5,
        PH_TERM   = 3'd6
    } phase_t;

    typedef enum logic {
        KIND_VALUE_BYTE = 1'b0,
        KIND_STATUS     = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [CFG_W-1:0]     key_low;
        logic [CFG_W-1:0]     key_high;
        logic [KEY_IDX_W-1:0] key_length;
        logic                 value_kind;
        logic [LEN_W-1:0]     capacity;
    } cfg_t;

    typedef struct packed {
        logic is_quote;
        logic is_colon;
        logic is_blank;
        logic is_t;
        logic is_f;
        logic is_term;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        eod;
        byte_class_t cls;
    } q_item_t;

    function automatic logic [7:0] keyword_char(input logic is_true, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (is_true)
        begin
            unique case (idx[1:0])
                2'd0: c = 8'h74;
                2'd1: c = 8'h72;
                2'd2: c = 8'h75;
                2'd3: c = 8'h65;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0: c = 8'h66;
                3'd1: c = 8'h61;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h73;
                3'd4: c = 8'h65;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/jkv_front.sv
module jkv_front (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              push_ready,
    output logic              push,
    output jkv_pkg::q_item_t  push_item
);
    import jkv_pkg::*;

    byte_class_t cls;

    always_comb
    begin
        cls.is_quote = (s_axis_tdata == CHAR_QUOTE);
        cls.is_colon = (s_axis_tdata == CHAR_COLON);
        cls.is_blank = (s_axis_tdata == CHAR_SPACE) || (s_axis_tdata == CHAR_TAB)
                     || (s_axis_tdata == CHAR_LF) || (s_axis_tdata == CHAR_CR);
        cls.is_t     = (s_axis_tdata == CHAR_T);
        cls.is_f     = (s_axis_tdata == CHAR_F);
        cls.is_term  = (s_axis_tdata == CHAR_COMMA) || (s_axis_tdata == CHAR_BRACE)
                     || (s_axis_tdata == CHAR_SPACE) || (s_axis_tdata == CHAR_LF);
    end

    assign s_axis_tready  = push_ready;
    assign push           = s_axis_tvalid && push_ready;
    assign push_item.data = s_axis_tdata;
    assign push_item.eod  = s_axis_tlast;
    assign push_item.cls  = cls;

endmodule

// File: hw/rtl/jkv_queue.sv
module jkv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jkv_pkg::q_item_t  push_item,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output jkv_pkg::q_item_t  pop_item
);
    import jkv_pkg::*;

    q_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/jkv_back.sv
module jkv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  jkv_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  jkv_pkg::q_item_t  q_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic [7:0]        out_byte,
    output logic [2:0]        out_status,
    output logic              out_bool
);
    import jkv_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [LEN_W-1:0]     vlen_reg, vlen_next;
    logic [2:0]           kw_idx_reg, kw_idx_next;
    logic                 kw_true_reg, kw_true_next;
    logic                 sent_reg, sent_next;

    logic                 out_valid_reg, out_valid_next;
    item_kind_t           out_kind_reg;
    logic [7:0]           out_byte_reg;
    status_t              out_status_reg;
    logic                 out_bool_reg;

    logic [KEY_IDX_W-1:0]     klen;
    logic [LEN_W-1:0]         cap;
    logic [2*CFG_W-1:0]       key_all;
    logic [7:0]               key_char;
    logic [2:0]               wlen;
    logic                     have_byte;
    logic                     have_status;
    status_t                  status;
    logic                     bval;

    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign klen    = (cfg.key_length > KEY_IDX_W'(KEY_BYTES)) ? KEY_IDX_W'(KEY_BYTES)
                                                              : cfg.key_length;
    assign cap     = (cfg.capacity > LEN_W'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : cfg.capacity;
    assign key_all = {cfg.key_high, cfg.key_low};
    assign key_char = key_all[kidx_reg[KEY_SEL_W-1:0]*8 +: 8];
    assign wlen    = kw_true_reg ? 3'd4 : 3'd5;

    always_comb
    begin
        phase_next   = phase_reg;
        kidx_next    = kidx_reg;
        vlen_next    = vlen_reg;
        kw_idx_next  = kw_idx_reg;
        kw_true_next = kw_true_reg;
        sent_next    = sent_reg;
        have_byte    = 1'b0;
        have_status  = 1'b0;
        status       = STATUS_OK;
        bval         = 1'b0;

        if (pop && !sent_reg)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (q_item.cls.is_quote)
                    begin
                        phase_next = PH_CAND;
                        kidx_next  = '0;
                    end
                end
                PH_CAND:
                begin
                    if (q_item.cls.is_quote)
                    begin
                        if (klen != '0 && kidx_reg == klen)
                        begin
                            phase_next = PH_COLON;
                        end
                        else
                        begin
                            kidx_next = '0;
                        end
                    end
                    else if (kidx_reg < klen && q_item.data == key_char)
                    begin
                        kidx_next = kidx_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                    end
                end
                PH_COLON:
                begin
                    if (q_item.cls.is_colon)
                    begin
                        phase_next = PH_BLANK;
                    end
                end
                PH_BLANK:
                begin
                    if (!q_item.cls.is_blank)
                    begin
                        if (!cfg.value_kind)
                        begin
                            if (q_item.cls.is_quote)
                            begin
                                phase_next = PH_STRING;
                                vlen_next  = '0;
                            end
                            else
                            begin
                                have_status = 1'b1;
                                status      = STATUS_WRONG_TYPE;
                            end
                        end
                        else if (q_item.cls.is_t || q_item.cls.is_f)
                        begin
                            phase_next   = PH_WORD;
                            kw_true_next = q_item.cls.is_t;
                            kw_idx_next  = 3'd1;
                        end
                        else
                        begin
                            have_status = 1'b1;
                            status      = STATUS_WRONG_TYPE;
                        end
                    end
                end
                PH_STRING:
                begin
                    if (q_item.cls.is_quote)
                    begin
                        have_status = 1'b1;
                        status      = (vlen_reg >= cap) ? STATUS_TOO_LONG : STATUS_OK;
                    end
                    else
                    begin
                        if (({1'b0, vlen_reg} + 1'b1) < {1'b0, cap})
                        begin
                            have_byte = 1'b1;
                        end
                        if (vlen_reg < cap)
                        begin
                            vlen_next = vlen_reg + 1'b1;
                        end
                    end
                end
                PH_WORD:
                begin
                    if (kw_idx_reg >= wlen)
                    begin
                        have_status = 1'b1;
                        status      = STATUS_WRONG_TYPE;
                    end
                    else if (q_item.data == keyword_char(kw_true_reg, kw_idx_reg))
                    begin
                        kw_idx_next = kw_idx_reg + 1'b1;
                        if (kw_idx_reg + 1'b1 == wlen)
                        begin
                            phase_next = PH_TERM;
                        end
                    end
                    else
                    begin
                        have_status = 1'b1;
                        status      = STATUS_WRONG_TYPE;
                    end
                end
                PH_TERM:
                begin
                    have_status = 1'b1;
                    if (q_item.cls.is_term)
                    begin
                        bval = kw_true_reg;
                    end
                    else
                    begin
                        status = STATUS_WRONG_TYPE;
                    end
                end
                default:
                begin
                    have_status = 1'b1;
                    status      = STATUS_WRONG_TYPE;
                end
            endcase

            // document closes without a status yet: judge by where parsing stands
            if (q_item.eod && !have_status)
            begin
                have_byte   = 1'b0;
                have_status = 1'b1;
                if (phase_next == PH_SEARCH || phase_next == PH_CAND || phase_next == PH_COLON)
                begin
                    status = STATUS_NOT_FOUND;
                end
                else if (phase_next == PH_STRING)
                begin
                    status = STATUS_UNTERMINATED;
                end
                else
                begin
                    status = STATUS_WRONG_TYPE;
                end
            end
        end

        if (pop)
        begin
            if (q_item.eod)
            begin
                phase_next   = PH_SEARCH;
                kidx_next    = '0;
                vlen_next    = '0;
                kw_idx_next  = '0;
                kw_true_next = 1'b0;
                sent_next    = 1'b0;
            end
            else if (have_status)
            begin
                sent_next = 1'b1;
            end
        end

        if (pop)
        begin
            out_valid_next = have_byte || have_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            kidx_reg      <= '0;
            vlen_reg      <= '0;
            kw_idx_reg    <= '0;
            kw_true_reg   <= 1'b0;
            sent_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kidx_reg      <= kidx_next;
            vlen_reg      <= vlen_next;
            kw_idx_reg    <= kw_idx_next;
            kw_true_reg   <= kw_true_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_kind_reg   <= have_status ? KIND_STATUS : KIND_VALUE_BYTE;
            out_byte_reg   <= have_status ? 8'h00 : q_item.data;
            out_status_reg <= have_status ? status : STATUS_OK;
            out_bool_reg   <= have_status ? bval : 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_bool   = out_bool_reg;

endmodule

// File: hw/rtl/json_key_value_extractor.sv
// channel   | dir | tdata (low bit up)                              | tuser      | tlast
// s_axis    | in  | data_byte[7:0]                                  | -          | end_of_document
// m_axis    | out | value_byte[7:0] result_status[10:8] bool[11]    | item_kind  | -
// cfg       | in  | cfg_we, cfg_index (register number), cfg_data (write value)
//
// one byte per cycle unless m_axis stalls; input is queued, then registered at the output
// the front classifies bytes into a two-entry queue, the back parser owns the output register
// either side may stall on its own: the queue absorbs the back's output stalls
// rst_n resets parser state, queue pointers and config registers at once; no clearing pass
module json_key_value_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // value_byte, result_status, bool_value, zero pad
    output logic [0:0]  m_axis_tuser,    // item_kind
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import jkv_pkg::*;

    logic [CFG_W-1:0]     key_low_reg;
    logic [CFG_W-1:0]     key_high_reg;
    logic [KEY_IDX_W-1:0] key_length_reg;
    logic                 value_kind_reg;
    logic [LEN_W-1:0]     capacity_reg;
    cfg_t                 cfg;

    logic    push, push_ready, pop, q_valid;
    q_item_t push_item, q_item;
    logic       out_kind, out_bool;
    logic [7:0] out_byte;
    logic [2:0] out_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_IDX_W'(1);
            value_kind_reg <= 1'b0;
            capacity_reg   <= LEN_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg    <= cfg_data;
                CFG_KEY_HIGH: key_high_reg   <= cfg_data;
                CFG_KEY_LEN:  key_length_reg <= cfg_data[KEY_IDX_W-1:0];
                CFG_KIND:     value_kind_reg <= cfg_data[0];
                CFG_CAPACITY: capacity_reg   <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.key_low    = key_low_reg;
    assign cfg.key_high   = key_high_reg;
    assign cfg.key_length = key_length_reg;
    assign cfg.value_kind = value_kind_reg;
    assign cfg.capacity   = capacity_reg;

    jkv_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_ready    (push_ready),
        .push          (push),
        .push_item     (push_item)
    );

    jkv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    jkv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_bool   (out_bool)
    );

    assign m_axis_tdata = {4'b0000, out_bool, out_status, out_byte};
    assign m_axis_tuser = out_kind;

endmodule

// File: hw/rtl/jkv_checker.sv
module jkv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    import jkv_pkg::*;

    // a held result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_VALUE_BYTE) |-> m_axis_tdata[15:8] == 8'h00)
        else $error("value byte transfer carries status bits");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_STATUS)
            |-> m_axis_tdata[7:0] == 8'h00 && m_axis_tdata[15:12] == 4'h0
                && m_axis_tdata[10:8] <= STATUS_TOO_LONG)
        else $error("malformed status transfer");

    a_bool_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11]
            |-> m_axis_tuser[0] == KIND_STATUS && m_axis_tdata[10:8] == STATUS_OK)
        else $error("boolean set outside an ok status");

endmodule

bind json_key_value_extractor jkv_checker u_jkv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_json_key_value_extractor.sv
`timescale 1ns / 1ps

module tb_json_key_value_extractor;

    import jkv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BYTE_TARGET    = 1400;

    typedef struct {
        item_kind_t  kind;
        logic [7:0]  vbyte;
        status_t     status;
        logic        bval;
    } jkv_out_t;

    // tracks one document at a time and queues the outputs each byte should cause
    class jkv_scoreboard;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [4:0]  key_len;
        logic        kind_bool;
        logic [8:0]  capacity;
        phase_t      phase;
        logic [4:0]  match_idx;
        logic [8:0]  val_len;
        logic [2:0]  word_idx;
        logic        word_true;
        logic        status_sent;
        jkv_out_t    awaited[$];
        int          error_count;

        function new();
            key_lo      = '0;
            key_hi      = '0;
            key_len     = 5'd1;
            kind_bool   = 1'b0;
            capacity    = 9'd16;
            error_count = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            phase       = PH_SEARCH;
            match_idx   = '0;
            val_len     = '0;
            word_idx    = '0;
            word_true   = 1'b0;
            status_sent = 1'b0;
        endfunction

        function void set_register(cfg_index_t idx, logic [63:0] v);
            case (idx)
                CFG_KEY_LOW:  key_lo = v;
                CFG_KEY_HIGH: key_hi = v;
                CFG_KEY_LEN:  key_len = v[4:0];
                CFG_KIND:     kind_bool = v[0];
                CFG_CAPACITY: capacity = v[8:0];
                default:      ;
            endcase
        endfunction

        function logic [7:0] key_char(int i);
            return (i < 8) ? key_lo[8*(i%8) +: 8] : key_hi[8*(i%8) +: 8];
        endfunction

        function void scan_byte(logic [7:0] b, logic eod);
            int unsigned klen;
            int unsigned cap;
            bit          have_byte;
            bit          have_status;
            status_t     st;
            logic        bv;
            string       w;
            jkv_out_t    o;
            klen        = (key_len > 16) ? 16 : key_len;
            cap         = (capacity > 256) ? 256 : capacity;
            have_byte   = 1'b0;
            have_status = 1'b0;
            st          = STATUS_OK;
            bv          = 1'b0;
            if (!status_sent)
            begin
                case (phase)
                    PH_SEARCH:
                        if (b == CHAR_QUOTE)
                        begin
                            phase     = PH_CAND;
                            match_idx = '0;
                        end
                    PH_CAND:
                        // a quote either closes a full match or restarts the candidate
                        if (b == CHAR_QUOTE)
                        begin
                            if (klen > 0 && match_idx == klen)
                                phase = PH_COLON;
                            else
                                match_idx = '0;
                        end
                        else if (match_idx < klen && b == key_char(match_idx))
                            match_idx++;
                        else
                            phase = PH_SEARCH;
                    PH_COLON:
                        if (b == CHAR_COLON)
                            phase = PH_BLANK;
                    PH_BLANK:
                        if (!(b inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR}))
                        begin
                            if (!kind_bool)
                            begin
                                if (b == CHAR_QUOTE)
                                begin
                                    phase   = PH_STRING;
                                    val_len = '0;
                                end
                                else
                                begin
                                    have_status = 1'b1;
                                    st          = STATUS_WRONG_TYPE;
                                end
                            end
                            else if (b == CHAR_T || b == CHAR_F)
                            begin
                                phase     = PH_WORD;
                                word_true = (b == CHAR_T);
                                word_idx  = 3'd1;
                            end
                            else
                            begin
                                have_status = 1'b1;
                                st          = STATUS_WRONG_TYPE;
                            end
                        end
                    PH_STRING:
                        if (b == CHAR_QUOTE)
                        begin
                            have_status = 1'b1;
                            st          = (val_len >= cap) ? STATUS_TOO_LONG : STATUS_OK;
                        end
                        else
                        begin
                            // room is kept for the terminator
                            if (val_len + 1 < cap)
                                have_byte = 1'b1;
                            if (val_len < cap)
                                val_len++;
                        end
                    PH_WORD:
                    begin
                        if (word_true)
                            w = "true";
                        else
                            w = "false";
                        if (word_idx >= w.len())
                        begin
                            have_status = 1'b1;
                            st          = STATUS_WRONG_TYPE;
                        end
                        else if (b == w[word_idx])
                        begin
                            word_idx++;
                            if (word_idx == w.len())
                                phase = PH_TERM;
                        end
                        else
                        begin
                            have_status = 1'b1;
                            st          = STATUS_WRONG_TYPE;
                        end
                    end
                    PH_TERM:
                    begin
                        have_status = 1'b1;
                        if (b inside {CHAR_COMMA, CHAR_BRACE, CHAR_SPACE, CHAR_LF})
                        begin
                            st = STATUS_OK;
                            bv = word_true;
                        end
                        else
                            st = STATUS_WRONG_TYPE;
                    end
                    default:
                    begin
                        have_status = 1'b1;
                        st          = STATUS_WRONG_TYPE;
                    end
                endcase

                if (eod && !have_status)
                begin
                    have_byte   = 1'b0;
                    have_status = 1'b1;
                    if (phase inside {PH_SEARCH, PH_CAND, PH_COLON})
                        st = STATUS_NOT_FOUND;
                    else if (phase == PH_STRING)
                        st = STATUS_UNTERMINATED;
                    else
                        st = STATUS_WRONG_TYPE;
                end
            end

            if (eod)
                clear_doc();
            else if (have_status)
                status_sent = 1'b1;

            if (have_status)
            begin
                o.kind   = KIND_STATUS;
                o.vbyte  = 8'h00;
                o.status = st;
                o.bval   = bv;
                awaited.push_back(o);
            end
            else if (have_byte)
            begin
                o.kind   = KIND_VALUE_BYTE;
                o.vbyte  = b;
                o.status = STATUS_OK;
                o.bval   = 1'b0;
                awaited.push_back(o);
            end
        endfunction

        task report(string msg);
            error_count++;
            $display("mismatch: %s", msg);
        endtask

        task check_output(logic [15:0] data, logic [0:0] user);
            jkv_out_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("output with nothing pending: tdata %h tuser %b", data, user));
                return;
            end
            e = awaited.pop_front();
            if (user[0] !== e.kind)
                report($sformatf("item_kind %b, expected %b", user[0], e.kind));
            if (data[7:0] !== e.vbyte)
                report($sformatf("value_byte %h, expected %h", data[7:0], e.vbyte));
            if (data[10:8] !== e.status)
                report($sformatf("result_status %0d, expected %0d", data[10:8], e.status));
            if (data[11] !== e.bval)
                report($sformatf("bool_value %b, expected %b", data[11], e.bval));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_KEY_LOW;
    logic [63:0] cfg_data = 64'd0;

    jkv_scoreboard sb = new();

    logic [7:0] doc[$];
    logic [7:0] key_chars[16];
    int         klen_eff = 1;
    bit         kind_mode = 1'b0;
    int         cap_eff = 16;
    bit         calm = 1'b0;
    int         bytes_sent = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;

    json_key_value_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // data_byte
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // value_byte, result_status, bool_value, zero pad
        .m_axis_tuser  (m_axis_tuser),    // item_kind
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sample every transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.scan_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("json_key_value_extractor regression: fail");
                $finish;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm)
                stall_left <= pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_doc();
        int i;
        for (i = 0; i < doc.size(); i++)
            send_byte(doc[i], i == doc.size() - 1);
        doc.delete();
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endtask

    task automatic add_blanks();
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
            case ($urandom_range(0, 3))
                0:       doc.push_back(CHAR_SPACE);
                1:       doc.push_back(CHAR_TAB);
                2:       doc.push_back(CHAR_LF);
                default: doc.push_back(CHAR_CR);
            endcase
    endtask

    // a pair whose key shares a prefix with the real one, sometimes all of it
    task automatic add_decoy();
        int m;
        int i;
        m = $urandom_range(0, klen_eff);
        doc.push_back(CHAR_QUOTE);
        for (i = 0; i < m; i++)
            doc.push_back(key_chars[i]);
        if (m == 0 || $urandom_range(0, 1))
            doc.push_back(8'($urandom_range(8'h61, 8'h7a)));
        if ($urandom_range(0, 1))
            add_text("\":\"v\",");
        else
            add_text("\":1,");
    endtask

    task automatic random_doc();
        int         r;
        int         n;
        int         i;
        int         cut;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            n = $urandom_range(1, 16);
            for (i = 0; i < n; i++)
                doc.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 1))
                add_text("{");
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                add_decoy();

            // the key itself, now and then truncated, corrupted or extended
            doc.push_back(CHAR_QUOTE);
            r = $urandom_range(0, 9);
            n = (r == 1 && klen_eff > 0) ? klen_eff - 1 : klen_eff;
            for (i = 0; i < n; i++)
                doc.push_back(key_chars[i]);
            if (r == 0 && n > 0)
                doc[doc.size() - 1] = doc[doc.size() - 1] ^ (8'h01 << $urandom_range(0, 7));
            if (r == 2)
                doc.push_back(8'($urandom_range(8'h61, 8'h7a)));
            doc.push_back(CHAR_QUOTE);

            add_blanks();
            if ($urandom_range(0, 15) != 0)
                doc.push_back(CHAR_COLON);
            add_blanks();

            r = $urandom_range(0, 99);
            if (!kind_mode && r < 88)
            begin
                doc.push_back(CHAR_QUOTE);
                r = $urandom_range(0, 99);
                if (r < 60)
                    n = $urandom_range(0, 8);
                else if (r < 95 && cap_eff <= 40)
                    n = (cap_eff < 2) ? $urandom_range(0, 2)
                                      : $urandom_range(cap_eff - 2, cap_eff + 1);
                else if (r < 97 || cap_eff < 200)
                    n = $urandom_range(0, 20);
                else
                    n = $urandom_range(250, 262);
                for (i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_QUOTE)
                        c = 8'h00;
                    doc.push_back(c);
                end
                doc.push_back(CHAR_QUOTE);
            end
            else if (kind_mode && r < 88)
            begin
                if (r < 6)
                    add_text("fa1se");
                else if (r < 10)
                    add_text("tru");
                else if (r[0])
                    add_text("true");
                else
                    add_text("false");
                case ($urandom_range(0, 6))
                    0:       doc.push_back(CHAR_COMMA);
                    1:       doc.push_back(CHAR_BRACE);
                    2:       doc.push_back(CHAR_SPACE);
                    3:       doc.push_back(CHAR_LF);
                    4:       doc.push_back(CHAR_TAB);
                    5:       doc.push_back(8'h78);
                    default: doc.push_back(CHAR_QUOTE);
                endcase
            end
            else if (r < 94)
                add_text("true");
            else
                add_text("\"7\"");

            if ($urandom_range(0, 2) == 0)
                add_decoy();
            add_text("}");

            // early end of document
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, doc.size());
                while (doc.size() > cut)
                    void'(doc.pop_back());
            end
        end
    endtask

    // let every outstanding output drain before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi, input int len,
                             input bit kind, input int cap);
        logic [63:0] junk;
        int          i;
        junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        for (i = 0; i < 16; i++)
            key_chars[i] = (i < 8) ? lo[8*(i%8) +: 8] : hi[8*(i%8) +: 8];
        klen_eff  = (len > 16) ? 16 : len;
        kind_mode = kind;
        cap_eff   = (cap > 256) ? 256 : cap;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY_LOW;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_KEY_HIGH;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= CFG_KEY_LEN;
        cfg_data  <= {junk[63:5], len[4:0]};
        @(negedge clk);
        cfg_index <= CFG_KIND;
        cfg_data  <= {junk[63:1], kind};
        @(negedge clk);
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= {junk[63:9], cap[8:0]};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        int          len;
        int          cap;
        int          rk;
        int          rl;
        int          rc;
        int          pos;
        int          i;
        int          n_docs;
        int          phase_no;
        bit          kind;

        for (i = 0; i < 16; i++)
            key_chars[i] = 8'h00;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: one-byte key of zero, string values, capacity 16
        add_text("{\"");
        doc.push_back(8'h00);
        add_text("\":\"ab\"}");
        send_doc();
        settle();

        configure(64'h6B6F, 64'd0, 2, 1'b1, 16);
        add_text("\"ok\": true,");
        send_doc();
        add_text("{\"ok\":false}");
        send_doc();
        add_text("\"ok\":tru");
        send_doc();
        settle();

        configure(64'h6B6F, 64'd0, 2, 1'b0, 3);
        add_text("\"ok\":\"abc\"");
        send_doc();
        add_text("\"ok\":\"ab");
        send_doc();
        add_text("{\"zz\":1}");
        send_doc();
        settle();

        // the first phases pin the register extremes, later ones roam
        phase_no = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            rk = $urandom_range(0, 9);
            for (i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = 8'($urandom_range(8'h23, 8'h7e));
                hi[8*i +: 8] = 8'($urandom_range(8'h23, 8'h7e));
            end
            if (rk >= 7 || phase_no == 2)
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            if (rk == 9 || phase_no == 2)
            begin
                pos = $urandom_range(0, 15);
                if (pos < 8)
                    lo[8*pos +: 8] = CHAR_QUOTE;
                else
                    hi[8*(pos-8) +: 8] = CHAR_QUOTE;
            end

            rl = (phase_no < 4) ? phase_no : $urandom_range(0, 9);
            case (rl)
                0:       len = 0;
                1:       len = 16;
                2:       len = $urandom_range(0, 1) ? 31 : $urandom_range(17, 30);
                3:       len = 1;
                4, 5:    len = $urandom_range(9, 16);
                default: len = $urandom_range(1, 8);
            endcase

            rc = (phase_no < 4) ? phase_no : $urandom_range(0, 9);
            case (rc)
                0:       cap = 0;
                1:       cap = 1;
                2:       cap = 256;
                3:       cap = $urandom_range(0, 1) ? 511 : $urandom_range(257, 510);
                default: cap = $urandom_range(2, 24);
            endcase

            kind = (phase_no < 4) ? (phase_no == 3) : 1'($urandom_range(0, 1));
            calm = ($urandom_range(0, 3) == 0);
            configure(lo, hi, len, kind, cap);
            n_docs = $urandom_range(4, 10);
            repeat (n_docs)
            begin
                random_doc();
                send_doc();
            end
            settle();
            phase_no++;
        end

        if (sb.awaited.size() != 0)
            sb.report("outputs still expected at end of run");
        if (sb.error_count == 0)
            $display("json_key_value_extractor regression: pass");
        else
            $display("json_key_value_extractor regression: fail");
        $finish;
    end

endmodule
